// ===== hdl/block_sad_motion_detector_assert.svh =====
// ----------------------------------------------------------------------------
// block_sad_motion_detector assertion macros
// concurrent checks that can be switched off as a group with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef BLOCK_SAD_MOTION_DETECTOR_ASSERT_SVH
`define BLOCK_SAD_MOTION_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define BSMD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BSMD_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define BSMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/bsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmd_pkg
// shared widths, register indexes and types of the sad motion detector
// ----------------------------------------------------------------------------
`default_nettype none

package bsmd_pkg;

  // configuration port
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_COLS_USED     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_STRIDE    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROWS          = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES_PER_WIN = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHT        = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_SAD_THRESHOLD = 3'd5;

  // register widths
  localparam int GEOM_W   = 9;
  localparam int WIN_W    = 8;
  localparam int WEIGHT_W = 16;
  localparam int SAD_W    = 16;

  // register reset values
  localparam logic [GEOM_W-1:0]   COLS_USED_RST     = 9'd80;
  localparam logic [GEOM_W-1:0]   ROW_STRIDE_RST    = 9'd80;
  localparam logic [GEOM_W-1:0]   ROWS_RST          = 9'd45;
  localparam logic [WIN_W-1:0]    FRAMES_PER_WIN_RST = 8'd15;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST        = 16'd0;
  localparam logic [SAD_W-1:0]    SAD_THRESHOLD_RST = 16'd765;

  // window sum and average
  localparam int SUM_W = 25;
  localparam int AVG_W = 17;

  // limit scale: average * 3 * 100 against weight * area
  localparam int LIMIT_FACTOR = 3;
  localparam int PERCENT      = 100;
  localparam int SCALE        = LIMIT_FACTOR * PERCENT;
  localparam int SCALE_W      = 9;

  // stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } bsmd_div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/bsmd_divider.sv =====
// ----------------------------------------------------------------------------
// bsmd_divider
// restoring divider, one quotient bit per cycle, holds the quotient until
// the next start
// ----------------------------------------------------------------------------
`default_nettype none

module bsmd_divider
  import bsmd_pkg::*;
#(
  parameter int DIV_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output bsmd_div_stat_t        stat,
  output logic      [SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] dvd;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             done;

  logic [DIV_W:0] rem_shift;
  logic           fits;
  logic [DIV_W:0] rem_sub;

  assign rem_shift = {rem, dvd[SUM_W-1]};
  assign fits      = rem_shift >= {1'b0, dsr};
  assign rem_sub   = rem_shift - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd <= dividend;
        dsr <= divisor;
        rem <= '0;
        cnt <= CNT_W'(SUM_W);
      end else if (cnt != '0) begin
        // quotient bits fill dvd from the bottom as the dividend leaves the top
        rem  <= fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        dvd  <= {dvd[SUM_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign quotient  = dvd;

endmodule

`default_nettype wire

// ===== hdl/block_sad_motion_detector.sv =====
// ----------------------------------------------------------------------------
// block_sad_motion_detector
// counts changed macroblocks per frame, averages over a window of frames and
// flags motion against a weighted area limit
// ----------------------------------------------------------------------------
// one sad entry per cycle while in the idle state; an entry that closes a window
// holds tready low through the divide, multiply and compare states:
//   25 steps of the restoring divider, two multiply stages, compare
// the result then sits in the output register until taken; a window close
// that finds it still full keeps tready low until it drains
// rst (synchronous) restores register defaults and clears position and sums
`default_nettype none

module block_sad_motion_detector
  import bsmd_pkg::*;
#(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 256,
  parameter int MAX_WINDOW = 255
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration writes
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  // sad entries
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] block_sad
  // window results
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata   // [0] motion_detected,
                                                     // [17:1] average_changed
);

`include "block_sad_motion_detector_assert.svh"

  localparam int CU_W  = $clog2(MAX_COLS + 1);
  localparam int RW_W  = $clog2(MAX_ROWS + 1);
  localparam int FW_W  = $clog2(MAX_WINDOW + 1);
  localparam int FC_W  = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int P1_W  = WEIGHT_W + CU_W;
  localparam int RHS_W = P1_W + RW_W;
  localparam int LHS_W = AVG_W + SCALE_W;
  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_A,
    ST_MUL_B,
    ST_CMP
  } state_t;

  // configuration registers
  logic [GEOM_W-1:0]   cols_used;
  logic [GEOM_W-1:0]   row_stride;
  logic [GEOM_W-1:0]   rows;
  logic [WIN_W-1:0]    frames_per_window;
  logic [WEIGHT_W-1:0] weight;
  logic [SAD_W-1:0]    sad_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_used         <= COLS_USED_RST;
      row_stride        <= ROW_STRIDE_RST;
      rows              <= ROWS_RST;
      frames_per_window <= FRAMES_PER_WIN_RST;
      weight            <= WEIGHT_RST;
      sad_threshold     <= SAD_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_COLS_USED:      cols_used         <= cfg_wdata[GEOM_W-1:0];
        CFG_ROW_STRIDE:     row_stride        <= cfg_wdata[GEOM_W-1:0];
        CFG_ROWS:           rows              <= cfg_wdata[GEOM_W-1:0];
        CFG_FRAMES_PER_WIN: frames_per_window <= cfg_wdata[WIN_W-1:0];
        CFG_WEIGHT:         weight            <= cfg_wdata[WEIGHT_W-1:0];
        CFG_SAD_THRESHOLD:  sad_threshold     <= cfg_wdata[SAD_W-1:0];
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize saturates
  logic [CU_W-1:0] cu;
  logic [CU_W-1:0] st;
  logic [RW_W-1:0] rw;
  logic [FW_W-1:0] fw;

  assign cu = (cols_used == '0) ? CU_W'(1) :
              (32'(cols_used) > 32'(MAX_COLS)) ? CU_W'(MAX_COLS) : CU_W'(cols_used);
  assign st = (row_stride == '0) ? CU_W'(1) :
              (32'(row_stride) > 32'(MAX_COLS)) ? CU_W'(MAX_COLS) : CU_W'(row_stride);
  assign rw = (rows == '0) ? RW_W'(1) :
              (32'(rows) > 32'(MAX_ROWS)) ? RW_W'(MAX_ROWS) : RW_W'(rows);
  assign fw = (frames_per_window == '0) ? FW_W'(1) :
              (32'(frames_per_window) > 32'(MAX_WINDOW)) ? FW_W'(MAX_WINDOW) :
              FW_W'(frames_per_window);

  // frame and window position
  state_t           state;
  logic [CU_W-1:0]  column_position;
  logic [RW_W-1:0]  row_position;
  logic [FC_W-1:0]  frame_changed_count;
  logic [FW_W-1:0]  frame_index;
  logic [SUM_W-1:0] window_sum;

  logic             s_accept;
  logic             hit;
  logic [CU_W:0]    col_inc;
  logic [RW_W:0]    row_inc;
  logic [FW_W:0]    fi_inc;
  logic             row_end;
  logic             frame_end;
  logic             window_close;
  logic [FC_W-1:0]  fcc_next;
  logic [SUM_W-1:0] window_sum_next;

  assign s_axis_tready   = (state == ST_IDLE);
  assign s_accept        = s_axis_tvalid && s_axis_tready;
  assign hit             = (column_position < cu) &&
                           (s_axis_tdata[SAD_W-1:0] > sad_threshold);
  assign col_inc         = {1'b0, column_position} + 1'b1;
  assign row_inc         = {1'b0, row_position} + 1'b1;
  assign fi_inc          = {1'b0, frame_index} + 1'b1;
  assign row_end         = col_inc >= {1'b0, st};
  assign frame_end       = row_end && (row_inc >= {1'b0, rw});
  assign window_close    = frame_end && (fi_inc >= {1'b0, fw});
  assign fcc_next        = frame_changed_count + FC_W'(hit);
  assign window_sum_next = window_sum + SUM_W'(fcc_next);

  // divider for the window average
  bsmd_div_stat_t   div_stat;
  logic [SUM_W-1:0] div_quot;
  logic [AVG_W-1:0] avg;

  bsmd_divider #(
    .DIV_W (FW_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (s_accept && window_close),
    .dividend (window_sum_next),
    .divisor  (fw),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  assign avg = div_quot[AVG_W-1:0];

  // limit products and output
  logic [P1_W-1:0]  prod_wc;
  logic [LHS_W-1:0] lhs;
  logic [RHS_W-1:0] rhs;
  logic             out_free;
  logic             motion;
  logic [AVG_W-1:0] avg_out;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      column_position     <= '0;
      row_position        <= '0;
      frame_changed_count <= '0;
      frame_index         <= '0;
      window_sum          <= '0;
      m_axis_tvalid       <= 1'b0;
    end else begin
      // in the compare state a taken result is replaced below
      if (m_axis_tvalid && m_axis_tready && state != ST_CMP) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            if (!row_end) begin
              column_position     <= col_inc[CU_W-1:0];
              frame_changed_count <= fcc_next;
            end else begin
              column_position <= '0;
              if (!frame_end) begin
                row_position        <= row_inc[RW_W-1:0];
                frame_changed_count <= fcc_next;
              end else begin
                row_position        <= '0;
                frame_changed_count <= '0;
                if (window_close) begin
                  window_sum  <= '0;
                  frame_index <= '0;
                  state       <= ST_DIV;
                end else begin
                  window_sum  <= window_sum_next;
                  frame_index <= fi_inc[FW_W-1:0];
                end
              end
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_MUL_A;
          end
        end
        ST_MUL_A: begin
          prod_wc <= P1_W'(weight) * P1_W'(cu);
          lhs     <= LHS_W'(avg) * LHS_W'(SCALE);
          state   <= ST_MUL_B;
        end
        ST_MUL_B: begin
          rhs   <= RHS_W'(prod_wc) * RHS_W'(rw);
          state <= ST_CMP;
        end
        ST_CMP: begin
          // wait for the output register to be free
          if (out_free) begin
            motion        <= CMP_W'(lhs) > CMP_W'(rhs);
            avg_out       <= avg;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({avg_out, motion});

  `BSMD_ASSERT_NEXT(a_close_starts_div, clk, rst, s_accept && window_close, div_stat.busy, "window close did not start the divider")
  `BSMD_ASSERT_NOW(a_done_in_div, clk, rst, div_stat.done, state == ST_DIV, "divider finished outside the divide state")
  `BSMD_ASSERT_NEXT(a_cmp_loads_out, clk, rst, state == ST_CMP && out_free, m_axis_tvalid && state == ST_IDLE, "result not loaded")
  `BSMD_ASSERT_NOW(a_div_idle_when_ready, clk, rst, state == ST_IDLE, !div_stat.busy, "divider busy while taking entries")

endmodule

`default_nettype wire

// ===== tb/block_sad_motion_detector_test.sv =====
// ----------------------------------------------------------------------------
// block_sad_motion_detector_test
// streams sad entries through the motion detector under several frame and
// window geometries, predicts each window decision in step with the accepted
// transactions and compares every result transaction field by field
// ----------------------------------------------------------------------------

module block_sad_motion_detector_test
  import bsmd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS_LIMIT   = 256;
  localparam int ROWS_LIMIT   = 256;
  localparam int WINDOW_LIMIT = 255;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  // indexes with no register behind them
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic             motion;
    logic [AVG_W-1:0] avg;
  } window_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [15:0] block_sad
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [0] motion_detected, [17:1] average_changed

  block_sad_motion_detector dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  logic [SAD_W-1:0] pending_sads[$];
  window_result_t   expected_windows[$];
  int               sads_queued = 0;
  int               sads_accepted = 0;
  int               windows_checked = 0;
  int               settings_count = 0;
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  logic             in_taken = 1'b0;

  // predictor copy of the registers and the counting state
  logic [GEOM_W-1:0]   reg_cols, reg_stride, reg_rows;
  logic [WIN_W-1:0]    reg_fpw;
  logic [WEIGHT_W-1:0] reg_weight;
  logic [SAD_W-1:0]    reg_thr;
  logic [7:0]          col_pos, row_pos, frame_idx;
  logic [AVG_W-1:0]    frame_count;
  logic [SUM_W-1:0]    window_sum;

  function automatic int unsigned sat_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic apply_register(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    case (addr)
      CFG_COLS_USED:      reg_cols   = data[GEOM_W-1:0];
      CFG_ROW_STRIDE:     reg_stride = data[GEOM_W-1:0];
      CFG_ROWS:           reg_rows   = data[GEOM_W-1:0];
      CFG_FRAMES_PER_WIN: reg_fpw    = data[WIN_W-1:0];
      CFG_WEIGHT:         reg_weight = data[WEIGHT_W-1:0];
      CFG_SAD_THRESHOLD:  reg_thr    = data[SAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_sad_entry(input logic [SAD_W-1:0] sad);
    int unsigned     cu, st, rw, fw;
    bit              row_end, frame_end;
    longint unsigned lhs, rhs;
    window_result_t  res;
    cu = sat_reg(reg_cols, COLS_LIMIT);
    st = sat_reg(reg_stride, COLS_LIMIT);
    rw = sat_reg(reg_rows, ROWS_LIMIT);
    fw = sat_reg(reg_fpw, WINDOW_LIMIT);
    // padding columns never count, even with a huge sad
    if (32'(col_pos) < cu && sad > reg_thr) frame_count = frame_count + 1'b1;
    // a position already past a shrunken stride or row count closes at once
    row_end   = (32'(col_pos) + 1 >= st);
    frame_end = row_end && (32'(row_pos) + 1 >= rw);
    if (!row_end) begin
      col_pos = col_pos + 1'b1;
    end else begin
      col_pos = '0;
      if (!frame_end) begin
        row_pos = row_pos + 1'b1;
      end else begin
        row_pos     = '0;
        window_sum  = window_sum + SUM_W'(frame_count);
        frame_count = '0;
        frame_idx   = frame_idx + 1'b1;
        if (32'(frame_idx) >= fw) begin
          res.avg    = AVG_W'(32'(window_sum) / fw);
          lhs        = 64'(res.avg) * SCALE;
          rhs        = 64'(reg_weight) * cu * rw;
          res.motion = (lhs > rhs);
          expected_windows.push_back(res);
          window_sum = '0;
          frame_idx  = '0;
        end
      end
    end
  endtask

  task automatic check_window_result(input logic [OUT_TDATA_W-1:0] data);
    window_result_t want;
    if (expected_windows.size() == 0) begin
      report_mismatch($sformatf("result 0x%0h with no window pending", data));
    end else begin
      want = expected_windows.pop_front();
      windows_checked++;
      if (data[0] !== want.motion)
        report_mismatch($sformatf("window %0d motion_detected %0b, want %0b",
                                  windows_checked, data[0], want.motion));
      if (data[AVG_W:1] !== want.avg)
        report_mismatch($sformatf("window %0d average_changed %0d, want %0d",
                                  windows_checked, data[AVG_W:1], want.avg));
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: configuration writes, accepted entries and result transactions
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      reg_cols    = COLS_USED_RST;
      reg_stride  = ROW_STRIDE_RST;
      reg_rows    = ROWS_RST;
      reg_fpw     = FRAMES_PER_WIN_RST;
      reg_weight  = WEIGHT_RST;
      reg_thr     = SAD_THRESHOLD_RST;
      col_pos     = '0;
      row_pos     = '0;
      frame_idx   = '0;
      frame_count = '0;
      window_sum  = '0;
      in_taken   <= 1'b0;
    end else begin
      if (cfg_we) apply_register(cfg_addr, cfg_wdata);
      if (m_axis_tvalid && m_axis_tready) check_window_result(m_axis_tdata);
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        sads_accepted++;
        predict_sad_entry(s_axis_tdata[SAD_W-1:0]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: entry stream and result back-pressure
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pending_sads.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_sads.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [SAD_W-1:0] pick_sad(input logic [SAD_W-1:0] thr);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return thr;
      3:       return thr + 1'b1;
      4:       return thr - 1'b1;
      default: return SAD_W'($urandom);
    endcase
  endfunction

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_detector(input logic [CFG_W-1:0] cols, stride, rows, fpw, wt, thr);
    cfg_write(CFG_COLS_USED, cols);
    cfg_write(CFG_ROW_STRIDE, stride);
    cfg_write(CFG_ROWS, rows);
    cfg_write(CFG_FRAMES_PER_WIN, fpw);
    cfg_write(CFG_WEIGHT, wt);
    cfg_write(CFG_SAD_THRESHOLD, thr);
    settings_count++;
  endtask

  task automatic queue_sad(input logic [SAD_W-1:0] sad);
    pending_sads.push_back(sad);
    sads_queued++;
  endtask

  task automatic queue_random_sads(input int n, input logic [SAD_W-1:0] thr);
    for (int i = 0; i < n; i++) queue_sad(pick_sad(thr));
  endtask

  // wait until every entry is taken and every window has come out
  task automatic settle();
    while (sads_accepted != sads_queued || expected_windows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_small_phase(input int n);
    logic [CFG_W-1:0] wt, thr;
    case ($urandom_range(0, 3))
      0:       wt = '0;
      1:       wt = 16'hFFFF;
      default: wt = CFG_W'($urandom_range(0, 600));
    endcase
    case ($urandom_range(0, 3))
      0:       thr = '0;
      1:       thr = 16'hFFFF;
      default: thr = CFG_W'($urandom_range(0, 65535));
    endcase
    program_detector(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 8)),
                     CFG_W'($urandom_range(1, 3)), CFG_W'($urandom_range(1, 3)), wt, thr);
    queue_random_sads(n, thr[SAD_W-1:0]);
    settle();
  endtask

  initial begin
    logic [SAD_W-1:0] mixed_frame [0:5];
    logic [CFG_W-1:0] thr;
    // two rows of three stored entries, the third one padding
    mixed_frame = '{16'd0, 16'd765, 16'hFFFF, 16'd766, 16'hFFFF, 16'hFFFF};

    send_idle_pct = 17;
    recv_idle_pct = 54;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: threshold equality, padding, empty frame, limit equality
    program_detector(16'd2, 16'd3, 16'd2, 16'd1, 16'd1, 16'd765);
    foreach (mixed_frame[i]) queue_sad(mixed_frame[i]);
    for (int i = 0; i < 6; i++) queue_sad('0);
    settle();
    cfg_write(CFG_WEIGHT, 16'd150);
    foreach (mixed_frame[i]) queue_sad(mixed_frame[i]);
    settle();

    // zero geometry and window (upper write bits dropped): one window per entry
    thr = CFG_W'($urandom_range(0, 65535));
    program_detector(16'hFE00, 16'd0, 16'd0, 16'hFF00, 16'd0, thr);
    queue_random_sads(20, thr);
    settle();

    // stride below cols_used, heaviest weight
    program_detector(16'd5, 16'd3, 16'd2, 16'd3, 16'hFFFF, 16'd0);
    queue_random_sads(24, '0);
    settle();
    repeat (3) random_small_phase($urandom_range(8, 12));

    send_idle_pct = 54;
    recv_idle_pct = 17;

    // oversized cols and rows saturate to the limits, the tallest frame at a stride of one,
    // next frame left part way through
    thr = CFG_W'($urandom_range(0, 65535));
    program_detector(16'h01FF, 16'd1, 16'd300, 16'd1, CFG_W'($urandom_range(0, 300)), thr);
    queue_random_sads(258, thr);
    settle();
    cfg_write(CFG_SPARE_LO, CFG_W'($urandom));
    cfg_write(CFG_SPARE_HI, CFG_W'($urandom));
    repeat (3) random_small_phase($urandom_range(8, 12));

    send_idle_pct = 0;
    recv_idle_pct = 0;

    // longest window, then shrink it so the open window closes at the next frame
    thr = CFG_W'($urandom_range(0, 65535));
    program_detector(16'd1, 16'd1, 16'd1, 16'd255, CFG_W'($urandom_range(0, 2)), thr);
    queue_random_sads(258, thr);
    settle();
    program_detector(16'd2, 16'd2, 16'd1, 16'd2, 16'd1, 16'hFFFF);
    queue_random_sads(12, 16'hFFFF);
    settle();
    repeat (3) random_small_phase($urandom_range(8, 12));

    $display("run covered %0d sad entries and %0d window decisions", sads_accepted,
             windows_checked);
    $display("over %0d register settings, %0d mismatches", settings_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d windows still pending", cycle_count,
             expected_windows.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bsmd_pkg.sv
hdl/bsmd_divider.sv
hdl/block_sad_motion_detector.sv
tb/block_sad_motion_detector_test.sv
